FILE: hw/rtl/nat_pkg.sv
// Shared constants of the address and port translation table: result
// status codes, TCP flag values, register indexes, register reset values and parameter defaults.
// No dependencies.
`default_nettype none

package nat_pkg;

    // Result status codes
    localparam logic [2:0] STATUS_HIT     = 3'd0;
    localparam logic [2:0] STATUS_NEW     = 3'd1;
    localparam logic [2:0] STATUS_IN_MISS = 3'd2;
    localparam logic [2:0] STATUS_NO_PORT = 3'd3;
    localparam logic [2:0] STATUS_NOT_TCP = 3'd4;
    localparam logic [2:0] STATUS_TICK    = 3'd5;
    localparam logic [2:0] STATUS_FULL    = 3'd6;

    // TCP flag byte values, compared for exact equality
    localparam logic [7:0] TCP_FIN = 8'h01;
    localparam logic [7:0] TCP_ACK = 8'h10;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_EXT_ADDR  = 2'd0;
    localparam logic [1:0] REG_IDLE_TMO  = 2'd1;
    localparam logic [1:0] REG_PORT_BASE = 2'd2;

    // Register reset values
    localparam logic [15:0] IDLE_TMO_RESET  = 16'd60;
    localparam logic [15:0] PORT_BASE_RESET = 16'd12345;

    // Parameter defaults
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int PORT_COUNT_DEF    = 1024;
    localparam int BUCKET_BITS_DEF   = 8;

endpackage

`default_nettype wire

FILE: hw/rtl/nat_cell.sv
// One cell of the mapping ring: holds one table entry and its valid bit,
// and takes its neighbor's entry on every shift. No dependencies.
`default_nettype none

module nat_cell #(
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire logic             i_valid,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    // Clear valid on reset, advance on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: hw/rtl/nat_port_mapping_table.sv
// Top level of the TCP address and port translation table: a ring of
// entry cells, the scan and update sequencer and the register port.
// Depends on nat_pkg and nat_cell.
//
// One item is in work at a time; busy is high while it runs, though a
// non-TCP packet is answered from idle without raising busy. The entries
// sit in a ring of TABLE_ENTRIES cells that rotates one place per cycle
// during a scan or update pass, past a single compare point. A tick, a miss
// or a full table takes a scan pass and a decide step; a hit adds an update
// pass; a new mapping adds a search for a free port slot, one slot a cycle,
// before the update pass. Each result is on the result ports for one cycle
// with o_done high; the receiver cannot stall it. A new item may be started
// in the cycle that o_done is high.
`default_nettype none

module nat_port_mapping_table
    import nat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PORT_COUNT    = PORT_COUNT_DEF,
    parameter int BUCKET_BITS   = BUCKET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic        i_outbound,
    input  wire logic        i_is_tcp,
    input  wire logic [31:0] i_src_ip,
    input  wire logic [31:0] i_dst_ip,
    input  wire logic [15:0] i_src_port,
    input  wire logic [15:0] i_dst_port,
    input  wire logic [7:0]  i_tcp_flags,
    input  wire logic [31:0] i_seq_number,
    input  wire logic [31:0] i_ack_number,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [31:0]      o_new_address,
    output logic [15:0]      o_new_port,
    output logic [6:0]       o_removed_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int N    = TABLE_ENTRIES;
    localparam int SW   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int SPAN = (PORT_COUNT < TABLE_ENTRIES) ? PORT_COUNT : TABLE_ENTRIES;
    localparam int SPW  = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int PW   = (N > 1) ? $clog2(N) : 1;
    localparam int CW   = $clog2(N + 1);
    localparam int CH   = (32 + BUCKET_BITS - 1) / BUCKET_BITS;
    localparam int FW   = CH * BUCKET_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SLOT   = 3'd3;
    localparam logic [2:0] ST_APPLY  = 3'd4;

    typedef struct packed {
        logic [BUCKET_BITS-1:0] bucket;
        logic [31:0]            in_addr;
        logic [15:0]            in_port;
        logic [SW-1:0]          slot;
        logic                   in_fin;
        logic                   out_fin;
        logic [31:0]            in_seq;
        logic [31:0]            out_seq;
        logic [31:0]            in_ack;
        logic [31:0]            out_ack;
        logic [31:0]            last_used;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // Fold an address into BUCKET_BITS-wide chunks by XOR
    function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [31:0] a);
        logic [FW-1:0]          x;
        logic [BUCKET_BITS-1:0] h;
        x = FW'(a);
        h = '0;
        for (int i = 0; i < CH; i++) begin
            h = h ^ x[i*BUCKET_BITS +: BUCKET_BITS];
        end
        return h;
    endfunction

    // Configuration registers
    logic [31:0] r_ext_addr;
    logic [15:0] r_idle_tmo;
    logic [15:0] r_port_base;

    // Sequencer state
    logic [2:0]     r_state;
    logic [PW-1:0]  r_pos;
    logic [SPW-1:0] r_scnt;
    logic           r_tick;
    logic           r_outbound;
    logic           r_fin;
    logic           r_isack;
    logic [BUCKET_BITS-1:0] r_bucket;
    logic [31:0]    r_src_ip;
    logic [31:0]    r_dst_ip;
    logic [15:0]    r_src_port;
    logic [15:0]    r_dst_port;
    logic [31:0]    r_seq;
    logic [31:0]    r_ack;
    logic [31:0]    r_seconds;
    logic           r_hit_found;
    logic           r_free_found;
    logic [PW-1:0]  r_target;
    logic [PW-1:0]  r_free_pos;
    logic [31:0]    r_hit_addr;
    logic [15:0]    r_hit_port;
    logic [15:0]    r_hit_ext;
    logic           r_new;
    logic [SW-1:0]  r_slot;
    logic [SPAN-1:0] r_used;
    logic [CW-1:0]  r_removed;
    logic           r_done;
    logic [2:0]     r_status;
    logic [31:0]    r_naddr;
    logic [15:0]    r_nport;

    // Ring wiring: cell i takes from cell i+1, the last from the feedback
    logic   c_valid [N+1];
    t_entry c_data  [N+1];
    logic   fb_valid;
    t_entry fb_data;
    logic   w_shift;
    logic   hv;
    t_entry head;

    assign w_shift = (r_state == ST_SCAN) || (r_state == ST_APPLY);
    assign hv      = c_valid[0];
    assign head    = c_data[0];
    assign c_valid[N] = fb_valid;
    assign c_data[N]  = fb_data;

    for (genvar g = 0; g < N; g++) begin : g_cell
        nat_cell #(
            .WIDTH (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_valid (c_valid[g+1]),
            .i_data  (c_data[g+1]),
            .o_valid (c_valid[g]),
            .o_data  (c_data[g])
        );
    end

    // Compare point at the head of the ring
    logic        w_accept;
    logic [15:0] w_head_ext;
    logic        w_match;
    logic        w_finished;
    logic        w_idle;
    logic        w_remove;
    logic [31:0] w_age;
    logic [15:0] w_slot_port;

    assign w_accept    = start && !busy;
    assign w_head_ext  = r_port_base + 16'(head.slot);
    assign w_slot_port = r_port_base + 16'(r_scnt);
    assign w_age       = r_seconds - head.last_used;
    assign w_finished  = head.in_fin && head.out_fin &&
                         (head.in_ack >= head.out_seq) && (head.out_ack >= head.in_seq);
    assign w_idle      = w_age > {16'b0, r_idle_tmo};
    assign w_remove    = hv && (w_finished || w_idle);

    always_comb begin
        if (r_outbound) begin
            w_match = hv && (head.bucket == r_bucket) && (head.in_addr == r_src_ip) &&
                      (head.in_port == r_src_port);
        end else begin
            w_match = hv && (head.bucket == r_bucket) && (r_dst_ip == r_ext_addr) &&
                      (w_head_ext == r_dst_port);
        end
    end

    // Feedback: drop finished or idle entries on a tick sweep, rewrite the target on update
    always_comb begin
        fb_valid = hv;
        fb_data  = head;
        if ((r_state == ST_SCAN) && r_tick && w_remove) begin
            fb_valid = 1'b0;
        end
        if ((r_state == ST_APPLY) && (r_pos == r_target)) begin
            if (r_new) begin
                fb_valid        = 1'b1;
                fb_data.bucket  = r_bucket;
                fb_data.in_addr = r_src_ip;
                fb_data.in_port = r_src_port;
                fb_data.slot    = r_slot;
                fb_data.out_fin = 1'b0;
                fb_data.out_seq = '0;
                fb_data.in_ack  = '0;
                fb_data.out_ack = '0;
            end
            if (r_outbound) begin
                fb_data.in_fin = r_fin;
                fb_data.in_seq = r_seq;
                if (r_isack) begin
                    fb_data.in_ack = r_ack;
                end
            end else begin
                fb_data.out_fin = r_fin;
                fb_data.out_seq = r_seq;
                if (r_isack) begin
                    fb_data.out_ack = r_ack;
                end
            end
            fb_data.last_used = r_seconds;
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_scnt       <= '0;
            r_seconds    <= '0;
            r_done       <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_used       <= '0;
            r_removed    <= '0;
            r_new        <= 1'b0;
            r_tick       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_hit_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_used       <= '0;
                        r_removed    <= '0;
                        r_new        <= 1'b0;
                        r_pos        <= '0;
                        r_tick       <= i_mode;
                        if (i_mode) begin
                            r_seconds <= r_seconds + 32'd1;
                            r_state   <= ST_SCAN;
                        end else if (!i_is_tcp) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_tick) begin
                        if (w_remove) begin
                            r_removed <= r_removed + CW'(1);
                        end
                    end else begin
                        if (w_match && !r_hit_found) begin
                            r_hit_found <= 1'b1;
                        end
                        if (!hv && !r_free_found) begin
                            r_free_found <= 1'b1;
                        end
                        if (hv && (32'(head.slot) < 32'(SPAN))) begin
                            r_used[head.slot[SPW-1:0]] <= 1'b1;
                        end
                    end
                    if (r_pos == PW'(N - 1)) begin
                        r_pos   <= '0;
                        r_state <= ST_DECIDE;
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                ST_DECIDE: begin
                    priority if (r_tick) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (r_hit_found) begin
                        r_state <= ST_APPLY;
                    end else if (!r_outbound || !r_free_found) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_scnt  <= '0;
                        r_state <= ST_SLOT;
                    end
                end
                ST_SLOT: begin
                    if (!r_used[r_scnt]) begin
                        r_new   <= 1'b1;
                        r_state <= ST_APPLY;
                    end else if (r_scnt == SPW'(SPAN - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_scnt <= r_scnt + SPW'(1);
                    end
                end
                ST_APPLY: begin
                    if (r_pos == PW'(N - 1)) begin
                        r_pos   <= '0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload, match captures and result values
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_outbound <= i_outbound;
                    r_fin      <= (i_tcp_flags == TCP_FIN);
                    r_isack    <= (i_tcp_flags == TCP_ACK);
                    r_bucket   <= bucket_of(i_outbound ? i_dst_ip : i_src_ip);
                    r_src_ip   <= i_src_ip;
                    r_dst_ip   <= i_dst_ip;
                    r_src_port <= i_src_port;
                    r_dst_port <= i_dst_port;
                    r_seq      <= i_seq_number;
                    r_ack      <= i_ack_number;
                    r_status   <= STATUS_NOT_TCP;
                    r_naddr    <= '0;
                    r_nport    <= '0;
                end
            end
            ST_SCAN: begin
                if (r_free_found == 1'b0 && !hv) begin
                    r_free_pos <= r_pos;
                end
                if (w_match && !r_hit_found) begin
                    r_target   <= r_pos;
                    r_hit_addr <= head.in_addr;
                    r_hit_port <= head.in_port;
                    r_hit_ext  <= w_head_ext;
                end
            end
            ST_DECIDE: begin
                r_naddr <= '0;
                r_nport <= '0;
                priority if (r_tick) begin
                    r_status <= STATUS_TICK;
                end else if (r_hit_found) begin
                    r_status <= STATUS_HIT;
                    r_naddr  <= r_outbound ? r_ext_addr : r_hit_addr;
                    r_nport  <= r_outbound ? r_hit_ext : r_hit_port;
                end else if (!r_outbound) begin
                    r_status <= STATUS_IN_MISS;
                end else begin
                    r_status <= STATUS_FULL;
                end
            end
            ST_SLOT: begin
                if (!r_used[r_scnt]) begin
                    r_slot   <= SW'(r_scnt);
                    r_target <= r_free_pos;
                    r_status <= STATUS_NEW;
                    r_naddr  <= r_ext_addr;
                    r_nport  <= w_slot_port;
                end else begin
                    r_status <= STATUS_NO_PORT;
                end
            end
            default: begin
            end
        endcase
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_addr  <= '0;
            r_idle_tmo  <= IDLE_TMO_RESET;
            r_port_base <= PORT_BASE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_EXT_ADDR:  r_ext_addr  <= pwdata;
                REG_IDLE_TMO:  r_idle_tmo  <= pwdata[15:0];
                REG_PORT_BASE: r_port_base <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_EXT_ADDR:  prdata = r_ext_addr;
            REG_IDLE_TMO:  prdata = {16'b0, r_idle_tmo};
            REG_PORT_BASE: prdata = {16'b0, r_port_base};
            default:       prdata = '0;
        endcase
    end

    logic [CW+6:0] w_removed_ext;
    assign w_removed_ext = {7'b0, r_removed};

    assign pready          = 1'b1;
    assign busy            = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_new_address   = r_naddr;
    assign o_new_port      = r_nport;
    assign o_removed_count = w_removed_ext[6:0];

    // An accepted item is either still in work or delivered next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (busy || o_done))
        else $error("accepted item neither in work nor delivered");

    // Only a tick reports removed mappings
    a_removed_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STATUS_TICK)) |-> (o_removed_count == 7'd0))
        else $error("packet result with nonzero removed count");

    // Ring is aligned whenever the sequencer rests
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pos == '0))
        else $error("ring position not aligned at rest");

endmodule

`default_nettype wire
